/* sv/shorten_header_bit_decoder_top_defines.svh */
// Assertion macros used by the checker file.
`ifndef SHORTEN_HEADER_BIT_DECODER_TOP_DEFINES_SVH
`define SHORTEN_HEADER_BIT_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SHDEC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SHDEC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/shdec_pkg.sv */
// ----------------------------------------------------------------------------
// shdec_pkg
// Types, constants and bit-step functions of the shorten header decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package shdec_pkg;

   localparam int HEADER_CAP     = 4096;
   localparam int UNARY_MAX      = 64;
   localparam int ULONG_WIDTH_MAX = 32;
   localparam int CMD_VERBATIM   = 9;
   localparam int VERSION_MIN    = 1;
   localparam int VERSION_MAX    = 3;
   localparam int WIDTH_BITS     = 2;   // uvar width of a ulong's width and of a command
   localparam int SKIP_BITS      = 7;
   localparam int LEN_BITS       = 5;
   localparam int BYTE_BITS      = 8;
   localparam int FIFO_DEPTH     = 8;
   localparam int FIFO_PTR_W     = $clog2(FIFO_DEPTH);

   localparam logic [7:0] MAGIC_BYTES [4] = '{8'h61, 8'h6A, 8'h6B, 8'h67};

   typedef enum logic [2:0] {
      PH_MAGIC   = 3'd0,
      PH_VERSION = 3'd1,
      PH_FWIDTH  = 3'd2,
      PH_FVALUE  = 3'd3,
      PH_SKIP    = 3'd4,
      PH_CMD     = 3'd5,
      PH_LEN     = 3'd6,
      PH_BYTES   = 3'd7
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_BAD_MAGIC   = 3'd1,
      ST_BAD_VERSION = 3'd2,
      ST_FIELDS      = 3'd3,
      ST_SKIP_LARGE  = 3'd4,
      ST_EMPTY       = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0] file_byte;
      logic       end_of_buffer;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  header_byte;
      logic [11:0] header_offset;
      logic [31:0] channels;
      logic [12:0] committed_length;
      status_type  status;
      logic        last;
   } rsp_type;

   typedef struct packed {
      phase_type   phase;
      logic [1:0]  magic_index;
      logic [2:0]  field_index;
      logic [6:0]  unary_run;
      logic [5:0]  suffix_left;
      logic [31:0] value_accum;
      logic [5:0]  ulong_width;
      logic [31:0] channel_count;
      logic [12:0] skip_left;
      logic [12:0] chunk_left;
      logic [12:0] header_count;
      logic [12:0] committed_count;
      logic        finished;
      logic        fault;
   } dec_state_type;

   // Decoder state plus the results produced so far for the current request.
   typedef struct packed {
      dec_state_type st;
      logic          byte_valid;
      logic [7:0]    byte_val;
      logic [11:0]   byte_offset;
      logic          sum_valid;
      status_type    sum_status;
   } step_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   function automatic dec_state_type reset_state();
      dec_state_type s;
      s = '0;
      s.phase = PH_MAGIC;
      return s;
   endfunction

   function automatic step_type emit_summary(input step_type cur, input status_type code);
      step_type r;
      r = cur;
      r.sum_valid = 1'b1;
      r.sum_status = code;
      r.st.finished = 1'b1;
      return r;
   endfunction

   function automatic step_type finish_gather(input step_type cur);
      step_type r;
      r = emit_summary(cur, (cur.st.committed_count != '0) ? ST_OK : ST_EMPTY);
      return r;
   endfunction

   function automatic step_type field_done(input step_type cur, input logic [31:0] v);
      step_type r;
      r = cur;
      if (r.st.field_index == 3'd1) begin
         r.st.channel_count = v;
      end
      if (r.st.field_index >= 3'd5) begin
         if (v > 32'(HEADER_CAP)) begin
            r = emit_summary(r, ST_SKIP_LARGE);
         end else if (r.st.fault || r.st.channel_count == '0) begin
            r = emit_summary(r, ST_FIELDS);
         end else begin
            r.st.skip_left = v[12:0];
            r.st.phase = (v != '0) ? PH_SKIP : PH_CMD;
         end
      end else begin
         r.st.field_index = r.st.field_index + 3'd1;
         r.st.phase = PH_FWIDTH;
      end
      return r;
   endfunction

   // Act on a completed uvar according to the phase it belongs to.
   function automatic step_type value_done(input step_type cur, input logic [31:0] v);
      step_type    r;
      logic [12:0] room;
      r = cur;
      room = 13'(HEADER_CAP) - r.st.header_count;
      case (r.st.phase)
         PH_FWIDTH: begin
            if (v > 32'(ULONG_WIDTH_MAX)) begin
               r.st.fault = 1'b1;
               r = field_done(r, '0);
            end else begin
               r.st.ulong_width = v[5:0];
               r.st.phase = PH_FVALUE;
            end
         end
         PH_FVALUE: r = field_done(r, v);
         PH_SKIP: begin
            if (r.st.fault) begin
               r = emit_summary(r, ST_FIELDS);
            end else begin
               r.st.skip_left = r.st.skip_left - 13'd1;
               if (r.st.skip_left == '0) begin
                  r.st.phase = PH_CMD;
               end
            end
         end
         PH_CMD: begin
            if (r.st.fault || v != 32'(CMD_VERBATIM)) begin
               r = finish_gather(r);
            end else begin
               r.st.phase = PH_LEN;
            end
         end
         PH_LEN: begin
            if (r.st.fault || v == '0 || v > {19'd0, room}) begin
               r = finish_gather(r);
            end else begin
               r.st.chunk_left = v[12:0];
               r.st.phase = PH_BYTES;
            end
         end
         PH_BYTES: begin
            if (r.st.fault) begin
               r = finish_gather(r);
            end else begin
               r.byte_valid = 1'b1;
               r.byte_val = v[7:0];
               r.byte_offset = r.st.header_count[11:0];
               r.st.header_count = r.st.header_count + 13'd1;
               r.st.chunk_left = r.st.chunk_left - 13'd1;
               if (r.st.chunk_left == '0) begin
                  r.st.committed_count = r.st.header_count;
                  r.st.phase = PH_CMD;
               end
            end
         end
         default: r = cur;
      endcase
      return r;
   endfunction

   // One bit of the stream, MSB first.
   function automatic step_type bit_step(input step_type cur, input logic b);
      step_type    r;
      logic        done;
      logic [31:0] v;
      logic [5:0]  w;
      logic [6:0]  run_next;
      r = cur;
      done = 1'b0;
      v = '0;
      run_next = r.st.unary_run + 7'd1;
      case (r.st.phase)
         PH_FWIDTH: w = 6'(WIDTH_BITS);
         PH_CMD:    w = 6'(WIDTH_BITS);
         PH_FVALUE: w = r.st.ulong_width;
         PH_SKIP:   w = 6'(SKIP_BITS);
         PH_LEN:    w = 6'(LEN_BITS);
         PH_BYTES:  w = 6'(BYTE_BITS);
         default:   w = '0;
      endcase
      if (!r.st.finished && r.st.phase != PH_MAGIC && r.st.phase != PH_VERSION) begin
         if (r.st.suffix_left != '0) begin
            r.st.value_accum = {r.st.value_accum[30:0], b};
            r.st.suffix_left = r.st.suffix_left - 6'd1;
            if (r.st.suffix_left == '0) begin
               done = 1'b1;
               v = r.st.value_accum;
            end
         end else if (!b) begin
            // over-long unary run: flag and yield zero
            if (r.st.fault || run_next > 7'(UNARY_MAX)) begin
               r.st.fault = 1'b1;
               r.st.unary_run = '0;
               done = 1'b1;
            end else begin
               r.st.unary_run = run_next;
            end
         end else begin
            r.st.value_accum = {25'd0, r.st.unary_run};
            r.st.unary_run = '0;
            if (w == '0) begin
               done = 1'b1;
               v = r.st.value_accum;
            end else begin
               r.st.suffix_left = w;
            end
         end
         if (done) begin
            r = value_done(r, v);
         end
      end
      return r;
   endfunction

   function automatic status_type exhaust_status(input dec_state_type s);
      logic [63:0] shifted;
      status_type  code;
      shifted = {32'd0, s.value_accum} << s.suffix_left;
      if (s.phase == PH_MAGIC || s.phase == PH_VERSION) begin
         code = ST_BAD_MAGIC;
      end else if (s.phase == PH_FVALUE && s.field_index >= 3'd5 && s.suffix_left != '0) begin
         // missing skip bits read as zero
         code = (shifted[31:0] > 32'(HEADER_CAP)) ? ST_SKIP_LARGE : ST_FIELDS;
      end else if (s.phase == PH_CMD || s.phase == PH_LEN || s.phase == PH_BYTES) begin
         code = (s.committed_count != '0) ? ST_OK : ST_EMPTY;
      end else begin
         code = ST_FIELDS;
      end
      return code;
   endfunction

endpackage

`default_nettype wire

/* sv/shdec_core.sv */
// ----------------------------------------------------------------------------
// shdec_core
// Request register, decoder state and the eight-bit step of one file byte.
// ----------------------------------------------------------------------------
`default_nettype none

module shdec_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  shdec_pkg::req_type     req_data,
   output logic                   busy,
   output shdec_pkg::push_type    push
);
   import shdec_pkg::*;

   logic          in_valid_ff;
   logic          in_valid_in;
   req_type       in_data_ff;
   dec_state_type state_ff;
   dec_state_type state_in;
   step_type      s;
   rsp_type       byte_rsp;
   rsp_type       sum_rsp;

   assign in_valid_in = accept;
   assign busy = in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff <= reset_state();
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
   end

   always_comb begin
      s = '0;
      s.st = state_ff;
      s.sum_status = ST_OK;
      if (in_valid_ff && !state_ff.finished) begin
         case (state_ff.phase)
            PH_MAGIC: begin
               if (in_data_ff.file_byte != MAGIC_BYTES[state_ff.magic_index]) begin
                  s = emit_summary(s, ST_BAD_MAGIC);
               end else if (state_ff.magic_index == 2'd3) begin
                  s.st.magic_index = '0;
                  s.st.phase = PH_VERSION;
               end else begin
                  s.st.magic_index = state_ff.magic_index + 2'd1;
               end
            end
            PH_VERSION: begin
               if (in_data_ff.file_byte < 8'(VERSION_MIN) ||
                   in_data_ff.file_byte > 8'(VERSION_MAX)) begin
                  s = emit_summary(s, ST_BAD_VERSION);
               end else begin
                  s.st.phase = PH_FWIDTH;
               end
            end
            default: begin
               for (int i = BYTE_BITS - 1; i >= 0; i--) begin
                  s = bit_step(s, in_data_ff.file_byte[i]);
               end
            end
         endcase
      end
      if (in_valid_ff && in_data_ff.end_of_buffer && !s.st.finished) begin
         s = emit_summary(s, exhaust_status(s.st));
      end
   end

   // End of buffer starts the next file from scratch.
   assign state_in = (in_valid_ff && in_data_ff.end_of_buffer) ? reset_state() : s.st;

   always_comb begin
      byte_rsp = '0;
      byte_rsp.kind = 1'b0;
      byte_rsp.header_byte = s.byte_val;
      byte_rsp.header_offset = s.byte_offset;
      byte_rsp.status = ST_OK;

      sum_rsp = '0;
      sum_rsp.kind = 1'b1;
      sum_rsp.channels = s.st.channel_count;
      sum_rsp.committed_length = s.st.committed_count;
      sum_rsp.status = s.sum_status;
      sum_rsp.last = 1'b1;

      push.count = {1'b0, s.byte_valid} + {1'b0, s.sum_valid};
      push.first = s.byte_valid ? byte_rsp : sum_rsp;
      push.second = sum_rsp;
   end

endmodule

`default_nettype wire

/* sv/shdec_out_fifo.sv */
// ----------------------------------------------------------------------------
// shdec_out_fifo
// Result queue taking up to two responses a cycle and giving one.
// ----------------------------------------------------------------------------
`default_nettype none

module shdec_out_fifo (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  shdec_pkg::push_type                push,
   input  wire logic                          pop,
   output logic [shdec_pkg::FIFO_PTR_W:0]     count,
   output logic                               out_valid,
   output shdec_pkg::rsp_type                 out_data
);
   import shdec_pkg::*;

   rsp_type                 entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff;
   logic [FIFO_PTR_W-1:0]   wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   wr_next;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff;
   logic [FIFO_PTR_W-1:0]   rd_ptr_in;
   logic [FIFO_PTR_W:0]     count_ff;
   logic [FIFO_PTR_W:0]     count_in;

   assign wr_next   = wr_ptr_ff + FIFO_PTR_W'(1);
   assign wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
   assign count_in  = count_ff + (FIFO_PTR_W + 1)'(push.count)
                      - (FIFO_PTR_W + 1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

   assign count     = count_ff;
   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];

endmodule

`default_nettype wire

/* sv/shorten_header_bit_decoder_top.sv */
// ----------------------------------------------------------------------------
// shorten_header_bit_decoder_top
// Byte-serial decoder for the header of a compressed audio file.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one file byte per request, with end_of_buffer on the last byte.
//   rsp_ gives gathered header bytes (kind 0) with their offsets and one
//   summary (kind 1, last 1) per file with channel count, committed length
//   and status. A byte gives at most one gathered byte and one summary.
//   A request is taken in each cycle in which req_stall is low: the byte is
//   registered, its eight bits pass through the decoder in the following
//   cycle, and its results enter the result queue at the end of that cycle.
//   Sustained rate is one request per cycle while req_stall stays low, set by
//   the single decode stage and the one-response-a-cycle result queue.
//   A stalled rsp_ side fills the eight-entry queue; req_stall rises while the
//   queue could not take two more results from each of the request in flight
//   and the next one. Bytes after a summary are dropped up to end_of_buffer.
//   Reset (synchronous) empties the queue and puts the decoder in the magic
//   phase; end_of_buffer returns it to the same state for the next file.
// ----------------------------------------------------------------------------
`default_nettype none

module shorten_header_bit_decoder_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  shdec_pkg::req_type     req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output shdec_pkg::rsp_type     rsp_data
);
   import shdec_pkg::*;

   logic                  accept;
   logic                  busy;
   push_type              push;
   logic [FIFO_PTR_W:0]   count;
   logic [FIFO_PTR_W+1:0] occupancy;

   // room for two results each from the request in flight and the next one
   assign occupancy = {1'b0, count} + (busy ? (FIFO_PTR_W + 2)'(2) : '0);
   assign req_stall = occupancy > (FIFO_PTR_W + 2)'(FIFO_DEPTH - 2);
   assign accept    = req_valid && !req_stall;

   shdec_core u_core (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .busy     (busy),
      .push     (push)
   );

   shdec_out_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_valid && !rsp_stall),
      .count     (count),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

endmodule

`default_nettype wire

/* sv/shdec_checker.sv */
// ----------------------------------------------------------------------------
// shdec_checker
// Port-level checks on the response channel of the header decoder.
// ----------------------------------------------------------------------------
`default_nettype none
`include "shorten_header_bit_decoder_top_defines.svh"

module shdec_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input shdec_pkg::rsp_type     rsp_data
);
   import shdec_pkg::*;

   `SHDEC_ASSERT_NOW(a_last_marks_summary, clock, reset, rsp_valid, rsp_data.last == rsp_data.kind, "last differs from kind")
   `SHDEC_ASSERT_NOW(a_byte_fields_clear, clock, reset, rsp_valid && !rsp_data.kind, rsp_data.status == ST_OK && rsp_data.channels == '0 && rsp_data.committed_length == '0, "summary fields set on a gathered byte")
   `SHDEC_ASSERT_NOW(a_ok_has_length, clock, reset, rsp_valid && rsp_data.kind && rsp_data.status == ST_OK, rsp_data.committed_length != '0, "ok status with nothing committed")
   `SHDEC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled response changed")

endmodule

bind shorten_header_bit_decoder_top shdec_checker u_checker (.*);

`default_nettype wire
